@@ rtl/fat_pkg.sv @@
// Shared types, codes and constants of the block chain allocator.
package fat_pkg;

    localparam int FAT_MAX_BLOCKS = 64;

    localparam int BLK_W   = 6;
    localparam int SIZE_W  = 24;
    localparam int BSIZE_W = 16;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 16;
    localparam int DIV_STEPS = SIZE_W;
    localparam int STEP_W  = $clog2(DIV_STEPS + 1);

    localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RESET  = 16'd512;
    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 7'd64;

    localparam logic [0:0] CFG_BLOCK_SIZE  = 1'b0;
    localparam logic [0:0] CFG_BLOCK_COUNT = 1'b1;

    localparam logic [1:0] OP_ALLOCATE = 2'd0;
    localparam logic [1:0] OP_WALK     = 2'd1;
    localparam logic [1:0] OP_FREE     = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_BAD_CHAIN = 2'd3;

    typedef struct packed {
        logic [1:0]         operation;
        logic [SIZE_W-1:0]  file_size;
        logic [BLK_W-1:0]   start_block;
    } fat_req_t;

    typedef struct packed {
        logic [BLK_W-1:0]   block_index;
        logic               last;
        logic [1:0]         status;
    } fat_rsp_t;

    typedef struct packed {
        logic               start;
        logic [SIZE_W-1:0]  dividend;
        logic [BSIZE_W-1:0] divisor;
    } fat_div_req_t;

    typedef struct packed {
        logic               busy;
        logic [SIZE_W-1:0]  need;
    } fat_div_stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DECIDE,
        S_ALLOC,
        S_CHECK,
        S_WALK,
        S_REPORT
    } fat_state_t;

endpackage

@@ rtl/fat_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module fat_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/fat_div.sv @@
// Bit-serial restoring divider giving the rounded-up block count of a byte size.
module fat_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fat_pkg::fat_div_req_t  req,
    output fat_pkg::fat_div_stat_t stat
);
    import fat_pkg::*;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [BSIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W-1:0] quo_reg, quo_next;
    logic [BSIZE_W-1:0] dvs_reg, dvs_next;

    logic [BSIZE_W:0]  shifted;
    logic [BSIZE_W:0]  diff;
    logic              fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[SIZE_W-1]};
        fits      = shifted >= {1'b0, dvs_reg};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_STEPS);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, remainder restored when it does not fit
            rem_next  = fits ? diff[BSIZE_W-1:0] : shifted[BSIZE_W-1:0];
            quo_next  = {quo_reg[SIZE_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.need = quo_reg + SIZE_W'(rem_reg != '0);

endmodule

@@ rtl/fat_chain_allocator.sv @@
// Top level of the block chain allocator: sequencer, block marks, link table, result register.
//
// A request arrives on req (req_valid/req_ready) and carries an operation, a byte size and a
// start block. Allocate rounds the size up to whole blocks, takes free blocks in ascending
// order, links them into a chain and returns every block taken. Walk returns the blocks of a
// chain in order; free does the same and releases each block it returns. Each request yields
// one or more results on rsp (rsp_valid/rsp_ready), the final one flagged by last; an unknown
// operation yields none. Configuration (block size, block count) is written on cfg_write.
// One request is in service at a time: req_ready is high only while the sequencer is idle.
// Allocate runs the serial divider and the free-block count side by side (N the usable block
// count), takes one decision step, then scans blocks in ascending order, at most N. Walk and
// free take one check step and then return one chain block at a time, as the link table has a
// single read port. A stalled receiver holds the result register and holds the sequencer at
// its next result; a transfer frees the register in the same cycle.
// Reset clears all used and end-of-chain marks (every block free) and restores block size
// 512 and block count 64; the link table needs no clearing, as an unlinked entry is never read.
module fat_chain_allocator #(
    parameter int MAX_BLOCKS = fat_pkg::FAT_MAX_BLOCKS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  fat_pkg::fat_req_t             req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output fat_pkg::fat_rsp_t             rsp,
    input  logic                          cfg_write,
    input  logic [0:0]                    cfg_index,
    input  logic [fat_pkg::CFG_W-1:0]     cfg_data
);
    import fat_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_BLOCKS);
    localparam logic [COUNT_W-1:0] K_LIMIT   = COUNT_W'(MAX_BLOCKS - 1);

    // control state
    fat_state_t          state_reg, state_next;
    logic [BSIZE_W-1:0]  bsize_reg, bsize_next;
    logic [COUNT_W-1:0]  bcount_reg, bcount_next;
    logic [MAX_BLOCKS-1:0] used_reg, used_next;
    logic [MAX_BLOCKS-1:0] end_reg, end_next;
    logic [MAX_BLOCKS-1:0] seen_reg, seen_next;
    logic [COUNT_W-1:0]  total_reg, total_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // working registers
    fat_rsp_t            rsp_reg, rsp_next;
    logic [BLK_W-1:0]    cur_reg, cur_next;
    logic [BLK_W-1:0]    prev_reg, prev_next;
    logic [COUNT_W-1:0]  scan_reg, scan_next;
    logic [COUNT_W-1:0]  avail_reg, avail_next;
    logic [COUNT_W-1:0]  taken_reg, taken_next;
    logic [COUNT_W-1:0]  k_reg, k_next;
    logic                clear_reg, clear_next;
    logic [BLK_W-1:0]    rep_blk_reg, rep_blk_next;
    logic [1:0]          rep_st_reg, rep_st_next;

    // divider and link table
    fat_div_req_t        div_req;
    fat_div_stat_t       div_stat;
    logic                link_we;
    logic [BLK_W-1:0]    link_rd;

    // decoded conditions
    logic                accept;
    logic                slot_free;
    logic [COUNT_W-1:0]  usable;
    logic [BSIZE_W-1:0]  bsize_eff;
    logic [IDX_W-1:0]    scan_idx;
    logic [IDX_W-1:0]    cur_idx;
    logic [IDX_W-1:0]    nx_idx;
    logic                scan_done;
    logic                alloc_free;
    logic                alloc_last;
    logic [COUNT_W-1:0]  taken_inc;
    logic                start_bad;
    logic                link_bad;
    logic                no_space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bsize_reg     <= BLOCK_SIZE_RESET;
            bcount_reg    <= BLOCK_COUNT_RESET;
            used_reg      <= '0;
            end_reg       <= '0;
            seen_reg      <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bsize_reg     <= bsize_next;
            bcount_reg    <= bcount_next;
            used_reg      <= used_next;
            end_reg       <= end_next;
            seen_reg      <= seen_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg     <= rsp_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        scan_reg    <= scan_next;
        avail_reg   <= avail_next;
        taken_reg   <= taken_next;
        k_reg       <= k_next;
        clear_reg   <= clear_next;
        rep_blk_reg <= rep_blk_next;
        rep_st_reg  <= rep_st_next;
    end

    fat_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // link table: written at the previous block while allocating, read at the current block
    fat_ram #(
        .WIDTH (BLK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_links (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (prev_reg[IDX_W-1:0]),
        .wr_data (scan_reg[BLK_W-1:0]),
        .rd_addr (cur_next[IDX_W-1:0]),
        .rd_data (link_rd)
    );

    // conditions shared by the next-state and datapath logic
    always_comb
    begin
        accept     = req_valid && req_ready;
        slot_free  = !rsp_valid_reg || rsp_ready;
        usable     = (bcount_reg > MAX_COUNT) ? MAX_COUNT : bcount_reg;
        bsize_eff  = (bsize_reg == '0) ? BSIZE_W'(1) : bsize_reg;
        scan_idx   = scan_reg[IDX_W-1:0];
        cur_idx    = cur_reg[IDX_W-1:0];
        nx_idx     = link_rd[IDX_W-1:0];
        scan_done  = scan_reg >= usable;
        alloc_free = !scan_done && !used_reg[scan_idx];
        taken_inc  = taken_reg + 1'b1;
        alloc_last = {{(SIZE_W-COUNT_W){1'b0}}, taken_inc} == div_stat.need;
        no_space   = div_stat.need > {{(SIZE_W-COUNT_W){1'b0}}, avail_reg};
        start_bad  = ({1'b0, cur_reg} >= usable) || !used_reg[cur_idx];
        link_bad   = ({1'b0, link_rd} >= usable) || !used_reg[nx_idx] || seen_reg[nx_idx]
                     || (k_reg >= K_LIMIT);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.operation)
                        OP_ALLOCATE: state_next = (req.file_size == '0) ? S_REPORT : S_DIV;
                        OP_WALK:     state_next = S_CHECK;
                        OP_FREE:     state_next = S_CHECK;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_DIV:
            begin
                if (!div_stat.busy && scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = no_space ? S_REPORT : S_ALLOC;
            end
            S_ALLOC:
            begin
                if (alloc_free && slot_free && alloc_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (!start_bad)
                begin
                    state_next = S_WALK;
                end
                else if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (slot_free && (end_reg[cur_idx] || link_bad))
                begin
                    state_next = S_IDLE;
                end
            end
            S_REPORT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        bsize_next   = bsize_reg;
        bcount_next  = bcount_reg;
        used_next    = used_reg;
        end_next     = end_reg;
        seen_next    = seen_reg;
        total_next   = total_reg;
        rsp_next     = rsp_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        scan_next    = scan_reg;
        avail_next   = avail_reg;
        taken_next   = taken_reg;
        k_next       = k_reg;
        clear_next   = clear_reg;
        rep_blk_next = rep_blk_reg;
        rep_st_next  = rep_st_reg;
        link_we      = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = req.file_size;
        div_req.divisor  = bsize_eff;

        // drop the held result once it has been transferred
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_BLOCK_SIZE:  bsize_next  = cfg_data[BSIZE_W-1:0];
                CFG_BLOCK_COUNT: bcount_next = cfg_data[COUNT_W-1:0];
                default:         bsize_next  = bsize_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cur_next     = req.start_block;
                    clear_next   = req.operation == OP_FREE;
                    scan_next    = '0;
                    avail_next   = '0;
                    rep_blk_next = '0;
                    rep_st_next  = ST_EMPTY;
                    if (req.operation == OP_ALLOCATE && req.file_size != '0)
                    begin
                        div_req.start = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                // count free blocks while the divider runs
                if (!scan_done)
                begin
                    avail_next = avail_reg + COUNT_W'(!used_reg[scan_idx]);
                    scan_next  = scan_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                rep_blk_next = '0;
                rep_st_next  = ST_NO_SPACE;
                scan_next    = '0;
                taken_next   = '0;
            end
            S_ALLOC:
            begin
                if (!alloc_free)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                else if (slot_free)
                begin
                    // link the previous block to this one, mark it, hand it out
                    link_we             = taken_reg != '0;
                    used_next[scan_idx] = 1'b1;
                    end_next[scan_idx]  = alloc_last;
                    total_next          = total_reg + 1'b1;
                    taken_next          = taken_inc;
                    prev_next           = scan_reg[BLK_W-1:0];
                    scan_next           = scan_reg + 1'b1;
                    rsp_valid_next      = 1'b1;
                    rsp_next.block_index = scan_reg[BLK_W-1:0];
                    rsp_next.last        = alloc_last;
                    rsp_next.status      = ST_OK;
                end
            end
            S_CHECK:
            begin
                if (!start_bad)
                begin
                    seen_next          = '0;
                    seen_next[cur_idx] = 1'b1;
                    k_next             = '0;
                end
                else if (slot_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.block_index = cur_reg;
                    rsp_next.last        = 1'b1;
                    rsp_next.status      = ST_BAD_CHAIN;
                end
            end
            S_WALK:
            begin
                if (slot_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.block_index = cur_reg;
                    if (end_reg[cur_idx])
                    begin
                        rsp_next.last   = 1'b1;
                        rsp_next.status = ST_OK;
                    end
                    else if (link_bad)
                    begin
                        rsp_next.last   = 1'b1;
                        rsp_next.status = ST_BAD_CHAIN;
                    end
                    else
                    begin
                        // advance along the link
                        rsp_next.last      = 1'b0;
                        rsp_next.status    = ST_OK;
                        cur_next           = link_rd;
                        seen_next[nx_idx]  = 1'b1;
                        k_next             = k_reg + 1'b1;
                    end
                    if (clear_reg)
                    begin
                        if (used_reg[cur_idx] && total_reg != '0)
                        begin
                            total_next = total_reg - 1'b1;
                        end
                        used_next[cur_idx] = 1'b0;
                        end_next[cur_idx]  = 1'b0;
                    end
                end
            end
            S_REPORT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.block_index = rep_blk_reg;
                    rsp_next.last        = 1'b1;
                    rsp_next.status      = rep_st_reg;
                end
            end
            default:
            begin
                rsp_valid_next = 1'b0;
            end
        endcase
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
